// ===== design/ctd_pkg.sv =====
// Package for the chunked transfer decoder: phase and outcome types,
// character codes and the hex digit decode. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ctd_pkg;

  localparam int SIZE_WIDTH_DEF = 32;  // default width of the chunk size
  localparam int COUNT_WIDTH    = 32;  // decoded byte count, wraps
  localparam int DIGIT_BITS     = 4;   // one hex digit

  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_0   = 8'h30;
  localparam logic [7:0] CH_9   = 8'h39;
  localparam logic [7:0] CH_LA  = 8'h61;  // 'a'
  localparam logic [7:0] CH_LF_ = 8'h66;  // 'f'
  localparam logic [7:0] CH_UA  = 8'h41;  // 'A'
  localparam logic [7:0] CH_UF  = 8'h46;  // 'F'
  localparam logic [7:0] CH_LX  = 8'h78;  // 'x'
  localparam logic [7:0] CH_UX  = 8'h58;  // 'X'

  typedef enum logic [2:0] {
    PH_LEAD    = 3'd0,  // leading blanks of a size line
    PH_ZERO    = 3'd1,  // a single leading 0 seen, 0x may follow
    PH_AFTERX  = 3'd2,  // after 0x
    PH_DIGITS  = 3'd3,  // inside the hex number
    PH_DATA    = 3'd4,  // chunk data
    PH_DATA_CR = 3'd5,  // expecting CR after data
    PH_DATA_LF = 3'd6,  // expecting LF after data
    PH_HALT    = 3'd7   // decoding done or failed
  } phase_t;

  typedef enum logic [2:0] {
    OC_RUNNING      = 3'd0,
    OC_COMPLETE     = 3'd1,
    OC_UNTERMINATED = 3'd2,
    OC_EMPTY_LINE   = 3'd3,
    OC_NO_DIGITS    = 3'd4,
    OC_TRUNCATED    = 3'd5,
    OC_NO_CRLF      = 3'd6,
    OC_OVERFLOW     = 3'd7
  } outcome_t;

  typedef struct packed {
    logic                  is_hex;
    logic [DIGIT_BITS-1:0] value;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t d;
    logic [7:0] diff;
    d    = '0;
    diff = '0;
    if (c >= CH_0 && c <= CH_9) begin
      diff = c - CH_0;
      d.is_hex = 1'b1;
      d.value  = diff[DIGIT_BITS-1:0];
    end else if (c >= CH_LA && c <= CH_LF_) begin
      diff = c - CH_LA + 8'd10;
      d.is_hex = 1'b1;
      d.value  = diff[DIGIT_BITS-1:0];
    end else if (c >= CH_UA && c <= CH_UF) begin
      diff = c - CH_UA + 8'd10;
      d.is_hex = 1'b1;
      d.value  = diff[DIGIT_BITS-1:0];
    end
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== design/chunked_transfer_decoder.sv =====
// Chunked transfer decoder, top level: per-byte parser with a result register.
// Depends on ctd_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Decodes a chunked HTTP body arriving one byte per word on the slave stream;
// tlast marks the final byte of a body. Every input word yields exactly one
// result word: the byte itself with a payload flag when it was chunk data,
// the running count of payload bytes for this body (wraps at 2^32), and an
// outcome code (0 running, 1 complete, 2 unterminated size line, 3 empty
// line, 4 no digits, 5 truncated, 6 no CR LF, 7 size overflow). Size lines
// allow leading spaces/tabs and an optional 0x; anything after the hex digits
// up to CR LF is ignored. A zero-size chunk completes the body and later bytes
// are ignored until tlast, after which the decoder is back at its start state.
// Throughput is one word per clock and the result is registered: the parser
// state update (hex decode, a SIZE_WIDTH shift/compare and a 32-bit count
// increment) sits between the input handshake and the result register.
// The input is stalled only while a result is held and the sink is not ready.
module chunked_transfer_decoder #(
  parameter int SIZE_WIDTH = ctd_pkg::SIZE_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] body_byte
  input  wire logic        s_axis_tlast,   // end_of_body
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // [7:0] payload_byte, [39:8] decoded_count
  output logic [3:0]       m_axis_tuser    // [0] payload_valid, [3:1] outcome
);

  localparam int CW = ctd_pkg::COUNT_WIDTH;
  localparam int DB = ctd_pkg::DIGIT_BITS;

  // parser state
  ctd_pkg::phase_t         phase, phase_next;
  logic                    pending_cr, pending_cr_next;
  logic                    line_nonempty, line_nonempty_next;
  logic                    digits_seen, digits_seen_next;
  logic                    number_ended, number_ended_next;
  logic [SIZE_WIDTH-1:0]   size_accum, size_accum_next;
  logic [SIZE_WIDTH-1:0]   bytes_left, bytes_left_next;
  logic [CW-1:0]           total_out, total_out_next;
  ctd_pkg::outcome_t       final_outcome, final_outcome_next;

  // result register
  logic [7:0]              out_byte;
  logic                    out_pvalid;
  logic [CW-1:0]           out_count;
  ctd_pkg::outcome_t       out_outcome;

  // per-word result before registering
  logic                    res_pvalid;
  ctd_pkg::outcome_t       res_outcome;

  logic                    in_accept;
  logic                    feed_ne;        // number ended, after a stray CR
  ctd_pkg::hex_digit_t     hd;
  logic [SIZE_WIDTH-1:0]   bytes_dec;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign hd            = ctd_pkg::hex_decode(s_axis_tdata);
  assign bytes_dec     = bytes_left - SIZE_WIDTH'(1);
  // a pending CR not followed by LF counts as a non-digit line character
  assign feed_ne       = number_ended || pending_cr;

  // next state
  always_comb begin
    phase_next         = phase;
    pending_cr_next    = pending_cr;
    line_nonempty_next = line_nonempty;
    digits_seen_next   = digits_seen;
    number_ended_next  = number_ended;
    size_accum_next    = size_accum;
    bytes_left_next    = bytes_left;
    total_out_next     = total_out;
    final_outcome_next = final_outcome;

    unique case (phase)
      ctd_pkg::PH_LEAD, ctd_pkg::PH_ZERO, ctd_pkg::PH_AFTERX,
      ctd_pkg::PH_DIGITS: begin
        if (pending_cr && s_axis_tdata == ctd_pkg::CH_LF) begin
          // end of size line
          pending_cr_next = 1'b0;
          if (!line_nonempty) begin
            phase_next         = ctd_pkg::PH_HALT;
            final_outcome_next = ctd_pkg::OC_EMPTY_LINE;
          end else if (!digits_seen) begin
            phase_next         = ctd_pkg::PH_HALT;
            final_outcome_next = ctd_pkg::OC_NO_DIGITS;
          end else if (size_accum == '0) begin
            phase_next         = ctd_pkg::PH_HALT;
            final_outcome_next = ctd_pkg::OC_COMPLETE;
          end else begin
            bytes_left_next = size_accum;
            phase_next      = ctd_pkg::PH_DATA;
          end
        end else begin
          line_nonempty_next = line_nonempty || pending_cr;
          number_ended_next  = feed_ne;
          if (s_axis_tdata == ctd_pkg::CH_CR) begin
            pending_cr_next = 1'b1;
          end else begin
            pending_cr_next    = 1'b0;
            line_nonempty_next = 1'b1;
            if (!feed_ne) begin
              if (phase == ctd_pkg::PH_LEAD &&
                  (s_axis_tdata == ctd_pkg::CH_SP || s_axis_tdata == ctd_pkg::CH_TAB)) begin
                // skip blank
              end else if (phase == ctd_pkg::PH_LEAD && s_axis_tdata == ctd_pkg::CH_0) begin
                digits_seen_next = 1'b1;
                phase_next       = ctd_pkg::PH_ZERO;
              end else if (phase == ctd_pkg::PH_ZERO &&
                           (s_axis_tdata == ctd_pkg::CH_LX ||
                            s_axis_tdata == ctd_pkg::CH_UX)) begin
                phase_next = ctd_pkg::PH_AFTERX;
              end else if (hd.is_hex) begin
                if (size_accum[SIZE_WIDTH-1 -: DB] != '0) begin
                  phase_next         = ctd_pkg::PH_HALT;
                  final_outcome_next = ctd_pkg::OC_OVERFLOW;
                end else begin
                  size_accum_next  = {size_accum[SIZE_WIDTH-DB-1:0], hd.value};
                  digits_seen_next = 1'b1;
                  phase_next       = ctd_pkg::PH_DIGITS;
                end
              end else begin
                number_ended_next = 1'b1;
              end
            end
          end
        end
      end
      ctd_pkg::PH_DATA: begin
        total_out_next  = total_out + CW'(1);
        bytes_left_next = bytes_dec;
        if (bytes_dec == '0) begin
          phase_next = ctd_pkg::PH_DATA_CR;
        end
      end
      ctd_pkg::PH_DATA_CR: begin
        if (s_axis_tdata == ctd_pkg::CH_CR) begin
          phase_next = ctd_pkg::PH_DATA_LF;
        end else begin
          phase_next         = ctd_pkg::PH_HALT;
          final_outcome_next = ctd_pkg::OC_NO_CRLF;
        end
      end
      ctd_pkg::PH_DATA_LF: begin
        if (s_axis_tdata == ctd_pkg::CH_LF) begin
          phase_next         = ctd_pkg::PH_LEAD;
          pending_cr_next    = 1'b0;
          line_nonempty_next = 1'b0;
          digits_seen_next   = 1'b0;
          number_ended_next  = 1'b0;
          size_accum_next    = '0;
        end else begin
          phase_next         = ctd_pkg::PH_HALT;
          final_outcome_next = ctd_pkg::OC_NO_CRLF;
        end
      end
      ctd_pkg::PH_HALT: begin
        // ignore bytes until end of body
      end
      default: begin
      end
    endcase
  end

  // result for this word
  always_comb begin
    res_pvalid  = (phase == ctd_pkg::PH_DATA);
    res_outcome = ctd_pkg::OC_RUNNING;
    if (phase_next == ctd_pkg::PH_HALT) begin
      res_outcome = final_outcome_next;
    end else if (s_axis_tlast) begin
      unique case (phase_next)
        ctd_pkg::PH_LEAD, ctd_pkg::PH_ZERO, ctd_pkg::PH_AFTERX,
        ctd_pkg::PH_DIGITS: begin
          res_outcome = (!line_nonempty_next && !pending_cr_next) ?
                        ctd_pkg::OC_COMPLETE : ctd_pkg::OC_UNTERMINATED;
        end
        ctd_pkg::PH_DATA:                     res_outcome = ctd_pkg::OC_TRUNCATED;
        ctd_pkg::PH_DATA_CR, ctd_pkg::PH_DATA_LF: res_outcome = ctd_pkg::OC_NO_CRLF;
        default:                              res_outcome = final_outcome_next;
      endcase
    end
  end

  // parser state registers; end of body returns to start
  always_ff @(posedge clk) begin
    if (rst || (in_accept && s_axis_tlast)) begin
      phase         <= ctd_pkg::PH_LEAD;
      pending_cr    <= 1'b0;
      line_nonempty <= 1'b0;
      digits_seen   <= 1'b0;
      number_ended  <= 1'b0;
      size_accum    <= '0;
      bytes_left    <= '0;
      total_out     <= '0;
      final_outcome <= ctd_pkg::OC_RUNNING;
    end else if (in_accept) begin
      phase         <= phase_next;
      pending_cr    <= pending_cr_next;
      line_nonempty <= line_nonempty_next;
      digits_seen   <= digits_seen_next;
      number_ended  <= number_ended_next;
      size_accum    <= size_accum_next;
      bytes_left    <= bytes_left_next;
      total_out     <= total_out_next;
      final_outcome <= final_outcome_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_byte    <= res_pvalid ? s_axis_tdata : 8'd0;
      out_pvalid  <= res_pvalid;
      out_count   <= total_out_next;
      out_outcome <= res_outcome;
    end
  end

  assign m_axis_tdata = {out_count, out_byte};
  assign m_axis_tuser = {out_outcome, out_pvalid};

  // checks
  a_data_nonzero_left: assert property (@(posedge clk) disable iff (rst)
    phase == ctd_pkg::PH_DATA |-> bytes_left != '0)
    else $error("chunk data phase with no bytes left");

  a_halt_has_code: assert property (@(posedge clk) disable iff (rst)
    phase == ctd_pkg::PH_HALT |-> final_outcome != ctd_pkg::OC_RUNNING)
    else $error("halted without an outcome code");

  a_data_word_out: assert property (@(posedge clk) disable iff (rst)
    in_accept && phase == ctd_pkg::PH_DATA |=> m_axis_tvalid && m_axis_tuser[0])
    else $error("data byte not passed out as payload");

  a_payload_outcome: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && out_pvalid |->
      (out_outcome == ctd_pkg::OC_RUNNING || out_outcome == ctd_pkg::OC_TRUNCATED ||
       out_outcome == ctd_pkg::OC_NO_CRLF))
    else $error("payload byte with an impossible outcome");

endmodule

`default_nettype wire

// ===== sim/chunked_transfer_decoder_tb.sv =====
// Testbench for the chunked transfer decoder: directed and random chunked bodies,
// with a scoreboard class that predicts every result word. Depends on ctd_pkg and the RTL.
`timescale 1ns / 1ps

module chunked_transfer_decoder_tb;

  localparam int SIZE_W      = ctd_pkg::SIZE_WIDTH_DEF;
  localparam int ITEM_TARGET = 500;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_OFF    = 200;    // long sink stall, fills the decoder
  localparam int DRAIN_WAIT  = 10;     // margin after the last expected result

  typedef struct {
    logic [7:0]        data;
    logic              valid;
    logic [31:0]       count;
    ctd_pkg::outcome_t oc;
  } dec_result_t;

  // Scoreboard: runs its own copy of the parser on every accepted byte and
  // keeps the predicted result words in order.
  class decoder_scoreboard;
    ctd_pkg::phase_t   ph;
    bit                pend_cr, line_seen, have_digits, num_done;
    logic [SIZE_W-1:0] size_acc;
    logic [31:0]       left, total;
    ctd_pkg::outcome_t halt_code;
    dec_result_t       expected_q[$];
    int                errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void clear_line();
      ph          = ctd_pkg::PH_LEAD;
      pend_cr     = 0;
      line_seen   = 0;
      have_digits = 0;
      num_done    = 0;
      size_acc    = '0;
    endfunction

    function void restart();
      clear_line();
      left      = '0;
      total     = '0;
      halt_code = ctd_pkg::OC_RUNNING;
    endfunction

    function void halt(ctd_pkg::outcome_t c);
      ph        = ctd_pkg::PH_HALT;
      halt_code = c;
    endfunction

    // One character of a size line (never the CR of a CR LF pair).
    function void size_char(logic [7:0] c);
      logic [3:0] nib;
      bit         is_hex;
      is_hex = 1;
      nib    = '0;
      if (c >= ctd_pkg::CH_0 && c <= ctd_pkg::CH_9) nib = 4'(c - ctd_pkg::CH_0);
      else if (c >= ctd_pkg::CH_LA && c <= ctd_pkg::CH_LF_)
        nib = 4'(c - ctd_pkg::CH_LA + 8'd10);
      else if (c >= ctd_pkg::CH_UA && c <= ctd_pkg::CH_UF)
        nib = 4'(c - ctd_pkg::CH_UA + 8'd10);
      else is_hex = 0;
      line_seen = 1;
      if (num_done) return;
      if (ph == ctd_pkg::PH_LEAD) begin
        if (c == ctd_pkg::CH_SP || c == ctd_pkg::CH_TAB) return;
        if (c == ctd_pkg::CH_0) begin
          have_digits = 1;
          ph = ctd_pkg::PH_ZERO;
          return;
        end
      end else if (ph == ctd_pkg::PH_ZERO && (c == ctd_pkg::CH_LX || c == ctd_pkg::CH_UX)) begin
        ph = ctd_pkg::PH_AFTERX;
        return;
      end
      if (is_hex) begin
        // next digit would push the size past SIZE_W bits
        if (size_acc[SIZE_W-1 -: 4] != 0) begin
          halt(ctd_pkg::OC_OVERFLOW);
          return;
        end
        size_acc    = {size_acc[SIZE_W-5:0], nib};
        have_digits = 1;
        ph          = ctd_pkg::PH_DIGITS;
      end else begin
        num_done = 1;
      end
    endfunction

    function void note_word(logic [7:0] b, logic last);
      dec_result_t r;
      bit          done;
      r.data  = '0;
      r.valid = 0;
      done    = 0;
      if (ph <= ctd_pkg::PH_DIGITS) begin
        if (pend_cr) begin
          pend_cr = 0;
          if (b == ctd_pkg::CH_LF) begin
            done = 1;
            if (!line_seen) halt(ctd_pkg::OC_EMPTY_LINE);
            else if (!have_digits) halt(ctd_pkg::OC_NO_DIGITS);
            else if (size_acc == 0) halt(ctd_pkg::OC_COMPLETE);
            else begin
              left = size_acc;
              ph   = ctd_pkg::PH_DATA;
            end
          end else begin
            size_char(ctd_pkg::CH_CR);   // lone CR is just a line character
          end
        end
        if (!done && ph <= ctd_pkg::PH_DIGITS) begin
          if (b == ctd_pkg::CH_CR) pend_cr = 1;
          else size_char(b);
        end
      end else begin
        case (ph)
          ctd_pkg::PH_DATA: begin
            r.valid = 1;
            r.data  = b;
            total++;
            left--;
            if (left == 0) ph = ctd_pkg::PH_DATA_CR;
          end
          ctd_pkg::PH_DATA_CR: begin
            if (b == ctd_pkg::CH_CR) ph = ctd_pkg::PH_DATA_LF;
            else halt(ctd_pkg::OC_NO_CRLF);
          end
          ctd_pkg::PH_DATA_LF: begin
            if (b == ctd_pkg::CH_LF) clear_line();
            else halt(ctd_pkg::OC_NO_CRLF);
          end
          default: ;
        endcase
      end
      r.oc = (ph == ctd_pkg::PH_HALT) ? halt_code : ctd_pkg::OC_RUNNING;
      if (last && ph != ctd_pkg::PH_HALT) begin
        if (ph <= ctd_pkg::PH_DIGITS)
          r.oc = (!line_seen && !pend_cr) ? ctd_pkg::OC_COMPLETE : ctd_pkg::OC_UNTERMINATED;
        else if (ph == ctd_pkg::PH_DATA) r.oc = ctd_pkg::OC_TRUNCATED;
        else r.oc = ctd_pkg::OC_NO_CRLF;
      end
      r.count = total;
      expected_q.push_back(r);
      if (last) restart();
    endfunction

    function void check_result(logic [39:0] d, logic [3:0] u);
      dec_result_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result word tdata=%h tuser=%h", $time, d, u);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (d[7:0] !== e.data) begin
        $display("%0t: payload_byte expected %h got %h", $time, e.data, d[7:0]);
        errors++;
      end
      if (u[0] !== e.valid) begin
        $display("%0t: payload_valid expected %b got %b", $time, e.valid, u[0]);
        errors++;
      end
      if (d[39:8] !== e.count) begin
        $display("%0t: decoded_count expected %0d got %0d", $time, e.count, d[39:8]);
        errors++;
      end
      if (u[3:1] !== e.oc) begin
        $display("%0t: outcome expected %0d got %0d", $time, e.oc, u[3:1]);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [3:0]  m_axis_tuser;

  decoder_scoreboard sb = new();
  int  words_in = 0;
  int  cycles = 0;
  bit  sender_bursty = 0;
  bit  held_long = 0;

  chunked_transfer_decoder dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Both handshakes are sampled at the rising edge; inputs move on the falling one.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_word(s_axis_tdata, s_axis_tlast);
        words_in++;
      end
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tdata, m_axis_tuser);
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] v, bit upper);
    if (v < 10) return ctd_pkg::CH_0 + 8'(v);
    return (upper ? ctd_pkg::CH_UA : ctd_pkg::CH_LA) + 8'(v) - 8'd10;
  endfunction

  // Sink: ready in random stretches, one long hold-off once traffic is going.
  initial begin
    int n;
    @(negedge clk);
    forever begin
      if (!held_long && words_in >= 120) begin
        held_long = 1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF) @(negedge clk);
      end
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
      m_axis_tready <= 1'b1;
      repeat (n) @(negedge clk);
      n = pick_gap();
      if (n > 0) begin
        m_axis_tready <= 1'b0;
        repeat (n) @(negedge clk);
      end
    end
  end

  // Called at a falling edge; returns at a falling edge after the gap.
  task automatic send_word(logic [7:0] b, logic last);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    gap = sender_bursty ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_body(ref logic [7:0] q[$]);
    foreach (q[i]) send_word(q[i], i == q.size() - 1);
  endtask

  task automatic add_text(ref logic [7:0] q[$], input string s);
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
  endtask

  // Size line with random blanks, 0x prefix, leading zeros, letter case and extension.
  task automatic add_size_line(ref logic [7:0] q[$], input logic [31:0] sz);
    int nd;
    nd = 1;
    if ($urandom_range(0, 9) < 3)
      repeat ($urandom_range(1, 2))
        q.push_back($urandom_range(0, 1) ? ctd_pkg::CH_SP : ctd_pkg::CH_TAB);
    if ($urandom_range(0, 3) == 0) begin
      q.push_back(ctd_pkg::CH_0);
      q.push_back($urandom_range(0, 1) ? ctd_pkg::CH_LX : ctd_pkg::CH_UX);
    end
    if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 2)) q.push_back(ctd_pkg::CH_0);
    for (int k = 7; k > 0; k--)
      if (sz[4*k +: 4] != 0) begin
        nd = k + 1;
        break;
      end
    for (int k = nd - 1; k >= 0; k--)
      q.push_back(hex_char(sz[4*k +: 4], 1'($urandom_range(0, 1))));
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 4)) q.push_back(8'($urandom_range(8'h21, 8'h7e)));
    q.push_back(ctd_pkg::CH_CR);
    q.push_back(ctd_pkg::CH_LF);
  endtask

  // Mostly well-formed bodies; nearly half are broken in one of several ways.
  task automatic make_body(ref logic [7:0] q[$]);
    int          r, cut;
    logic [31:0] sz;
    q.delete();
    repeat ($urandom_range(0, 3)) begin
      sz = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 8);
      add_size_line(q, sz);
      repeat (sz) q.push_back(8'($urandom_range(0, 255)));
      q.push_back(ctd_pkg::CH_CR);
      q.push_back(ctd_pkg::CH_LF);
    end
    add_size_line(q, 0);
    if ($urandom_range(0, 9) < 3)
      repeat ($urandom_range(1, 4)) q.push_back(8'($urandom_range(0, 255)));
    r = $urandom_range(0, 99);
    if (r < 12) begin
      cut = $urandom_range(1, q.size());
      while (q.size() > cut) void'(q.pop_back());
    end else if (r < 24) begin
      q[$urandom_range(0, q.size() - 1)] = 8'($urandom_range(0, 255));
    end else if (r < 30) begin
      // nine significant digits: overflow on the last one
      for (int k = 0; k < 8; k++)
        q.insert(0, hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
      q.insert(0, hex_char(4'($urandom_range(1, 15)), 1'b0));
    end else if (r < 34) begin
      q.push_front(ctd_pkg::CH_LF);
      q.push_front(ctd_pkg::CH_CR);
    end else if (r < 38) begin
      q.insert(0, $urandom_range(0, 1) ? 8'h2B : 8'h2D);   // sign before the size
    end else if (r < 42) begin
      q.insert(1, ctd_pkg::CH_CR);
    end else if (r < 47) begin
      q.delete();
      repeat ($urandom_range(1, 12)) q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    logic [7:0] body_q[$];
    bit         drained;
    drained = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty line
    body_q = {ctd_pkg::CH_CR, ctd_pkg::CH_LF};
    send_body(body_q);
    // blank, 0x, lone CR before CR LF, zero data byte, bytes ignored after completion
    body_q.delete();
    add_text(body_q, " 0x1");
    body_q.push_back(ctd_pkg::CH_CR);
    body_q.push_back(ctd_pkg::CH_CR);
    body_q.push_back(ctd_pkg::CH_LF);
    body_q.push_back(8'h00);
    body_q.push_back(ctd_pkg::CH_CR);
    body_q.push_back(ctd_pkg::CH_LF);
    body_q.push_back(ctd_pkg::CH_0);
    body_q.push_back(ctd_pkg::CH_CR);
    body_q.push_back(ctd_pkg::CH_LF);
    body_q.push_back(8'hFF);
    send_body(body_q);
    // size overflow, final byte on the offending digit
    body_q.delete();
    add_text(body_q, "123456789");
    send_body(body_q);

    while (words_in < ITEM_TARGET) begin
      make_body(body_q);
      sender_bursty = ($urandom_range(0, 3) == 0);
      send_body(body_q);
      if (!drained && words_in >= ITEM_TARGET / 2) begin
        drained = 1;
        s_axis_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(negedge clk);
      end
    end
    s_axis_tvalid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/ctd_pkg.sv
design/chunked_transfer_decoder.sv
sim/chunked_transfer_decoder_tb.sv
